/* hw/rtl/agfo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the audio gain and fade-out block.
// Used by agfo_ctrl, agfo_dp and audio_gain_fade_out_core; no dependencies.

package agfo_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int GAIN_BITS = 12;
    localparam int FRAME_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int PROD1_W  = MAG_W + GAIN_W;
    localparam int SCALED_W = PROD1_W - GAIN_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENDLESS_LOOP = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_MUL_GAIN,
        ST_MUL_FADE,
        ST_SATURATE,
        ST_DELIVER
    } agfo_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_gain;
        logic mul_fade;
        logic sat_store;
        logic out_load;
        logic chan;
    } agfo_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fading;
        logic past_end;
        logic out_busy;
    } agfo_status_t;

endpackage

`default_nettype wire

/* hw/rtl/audio_gain_fade_out_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Top level of the audio gain and fade-out block.
// Instantiates agfo_ctrl and agfo_dp; depends on agfo_pkg.

// Stereo gain and linear fade-out. Each beat on the input carries one stereo
// frame of 16-bit two's complement samples; each frame yields exactly one
// output beat. Both samples are scaled by volume_gain (unsigned Q4.12, 4096 is
// unity), truncated toward zero and saturated to 16 bits. A 32-bit frame
// counter starts at zero after reset, advances once per frame and holds at its
// top value. Outside endless mode, frames past fade_start (and before
// total_frames, with total_frames above fade_start) are also scaled by the
// fade fraction (total_frames - position) / (total_frames - fade_start),
// produced as unsigned Q0.FRACTION_BITS by a restoring divider, and flagged
// with fading. Frames at or beyond total_frames come out as zero with
// past_end set; after reset total_frames is 0, so outside endless mode every
// frame is muted until total_frames is written. After the accepting edge the
// sequencer checks the frame; a fading frame runs the divider, one quotient
// bit per cycle; then each channel in turn passes the gain multiply, the fade
// multiply (fading frames only) and saturation, sharing one multiplier pair;
// a frame past the end goes straight to delivery. Once the beat is loaded the
// input is ready again in the next cycle. The input is taken again as soon
// as a frame has been moved into the output register, so the next frame is in
// work while the previous result waits; a frame that finishes while the
// output register is still held waits there and stalls the input. Write
// configuration only while the block is idle.

module audio_gain_fade_out_core
    import agfo_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] left_sample,
    input  wire logic signed [SAMPLE_W-1:0] right_sample,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      left_out,
    output logic signed [SAMPLE_W-1:0]      right_out,
    output logic                            fading,
    output logic                            past_end
);

    agfo_cmd_t    cmd;
    agfo_status_t status;

    // Sequencer: accept a frame, then step the datapath through it
    agfo_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: registers, counter, divider, multipliers, output beat
    agfo_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_out     (left_out),
        .right_out    (right_out),
        .fading       (fading),
        .past_end     (past_end)
    );

endmodule

`default_nettype wire

/* hw/rtl/agfo_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequencer for the audio gain and fade-out block: walks one frame through
// divide, multiply and saturate steps. Depends on agfo_pkg.

module agfo_ctrl
    import agfo_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire agfo_status_t status,
    output agfo_cmd_t         cmd
);

    localparam int CNT_W = $clog2(FRACTION_BITS);

    agfo_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             chan_reg, chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        chan_next  = chan_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                chan_next = 1'b0;
                cnt_next  = CNT_W'(FRACTION_BITS - 1);
                if (status.past_end)
                    state_next = ST_DELIVER;
                else if (status.fading)
                    state_next = ST_DIVIDE;
                else
                    state_next = ST_MUL_GAIN;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_MUL_GAIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = status.fading ? ST_MUL_FADE : ST_SATURATE;
            end
            ST_MUL_FADE:
            begin
                cmd.mul_fade = 1'b1;
                state_next   = ST_SATURATE;
            end
            ST_SATURATE:
            begin
                cmd.sat_store = 1'b1;
                if (chan_reg == 1'b0)
                begin
                    chan_next  = 1'b1;
                    state_next = ST_MUL_GAIN;
                end
                else
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/agfo_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// Datapath for the audio gain and fade-out block: configuration registers,
// frame counter, restoring divider, multipliers, saturation and output
// register. Depends on agfo_pkg.

module agfo_dp
    import agfo_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_wdata,
    input  wire logic signed [SAMPLE_W-1:0] left_sample,
    input  wire logic signed [SAMPLE_W-1:0] right_sample,
    input  wire agfo_cmd_t                  cmd,
    output agfo_status_t                    status,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      left_out,
    output logic signed [SAMPLE_W-1:0]      right_out,
    output logic                            fading,
    output logic                            past_end
);

    localparam int PROD2_W = PROD1_W + FRACTION_BITS;

    // Configuration
    logic [GAIN_W-1:0]  volume_gain_reg;
    logic [FRAME_W-1:0] fade_start_reg;
    logic [FRAME_W-1:0] total_frames_reg;
    logic               endless_loop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_gain_reg  <= GAIN_UNITY;
            fade_start_reg   <= '0;
            total_frames_reg <= '0;
            endless_loop_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VOLUME_GAIN:  volume_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_FADE_START:   fade_start_reg   <= cfg_wdata[FRAME_W-1:0];
                REG_TOTAL_FRAMES: total_frames_reg <= cfg_wdata[FRAME_W-1:0];
                REG_ENDLESS_LOOP: endless_loop_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Frame counter and per-frame decisions
    logic [FRAME_W-1:0] position_reg;
    logic               fading_reg, past_end_reg;
    logic               past_now, fade_now;

    assign past_now = !endless_loop_reg && (position_reg >= total_frames_reg);
    assign fade_now = !endless_loop_reg && !past_now
                      && (total_frames_reg > fade_start_reg)
                      && (position_reg > fade_start_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            fading_reg   <= 1'b0;
            past_end_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            fading_reg   <= fade_now;
            past_end_reg <= past_now;
            if (position_reg != '1)
                position_reg <= position_reg + 1'b1;
        end
    end

    // Sample capture, divider, multipliers, saturation
    logic signed [SAMPLE_W-1:0] left_reg, right_reg;
    logic [FRAME_W-1:0]         rem_reg, len_reg;
    logic [FRACTION_BITS-1:0]   quot_reg;
    logic [PROD1_W-1:0]         prod1_reg;
    logic [PROD2_W-1:0]         prod2_reg;
    logic                       neg_reg;
    logic [SAMPLE_W-1:0]        res_left_reg, res_right_reg;

    logic [FRAME_W:0]           rem_shift;
    logic                       rem_ge;
    logic [SAMPLE_W-1:0]        sample_sel;
    logic                       sample_neg;
    logic [MAG_W-1:0]           mag;
    logic [SCALED_W-1:0]        scaled;
    logic [SAMPLE_W-1:0]        sat;

    assign rem_shift  = {rem_reg, 1'b0};
    assign rem_ge     = rem_shift >= {1'b0, len_reg};
    assign sample_sel = cmd.chan ? right_reg : left_reg;
    assign sample_neg = sample_sel[SAMPLE_W-1];
    assign mag        = sample_neg ? MAG_W'(18'h10000 - {2'b00, sample_sel})
                                   : {1'b0, sample_sel};
    assign scaled     = fading_reg ? prod2_reg[PROD2_W-1 -: SCALED_W]
                                   : prod1_reg[PROD1_W-1 -: SCALED_W];

    always_comb
    begin
        if (neg_reg)
        begin
            if (scaled > SCALED_W'(32768))
                sat = 16'h8000;
            else
                sat = 16'd0 - scaled[SAMPLE_W-1:0];
        end
        else
        begin
            if (scaled > SCALED_W'(32767))
                sat = 16'h7FFF;
            else
                sat = scaled[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
            rem_reg   <= total_frames_reg - position_reg;
            len_reg   <= total_frames_reg - fade_start_reg;
            quot_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? FRAME_W'(rem_shift - {1'b0, len_reg})
                               : rem_shift[FRAME_W-1:0];
            quot_reg <= {quot_reg[FRACTION_BITS-2:0], rem_ge};
        end
        if (cmd.mul_gain)
        begin
            prod1_reg <= PROD1_W'(mag) * PROD1_W'(volume_gain_reg);
            neg_reg   <= sample_neg;
        end
        if (cmd.mul_fade)
            prod2_reg <= PROD2_W'(prod1_reg) * PROD2_W'(quot_reg);
        if (cmd.sat_store)
        begin
            if (cmd.chan)
                res_right_reg <= sat;
            else
                res_left_reg <= sat;
        end
    end

    // Output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_out  <= past_end_reg ? '0 : res_left_reg;
            right_out <= past_end_reg ? '0 : res_right_reg;
            fading    <= fading_reg;
            past_end  <= past_end_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.fading   = fading_reg;
    assign status.past_end = past_end_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

`default_nettype wire
